// File: hw/rtl/tmbp_pkg.sv
`timescale 1ns / 1ps
// Package for the two-mask butterfly permuter: sizes, lane and bus types,
// and the per-stage conditional swap function. No dependencies.

package tmbp_pkg;

    localparam int LANES       = 4;
    localparam int LEVELS      = 2;
    localparam int ELEM_WIDTH  = 16;
    localparam int VEC_W       = 64;
    localparam int MASK_W      = 4;
    localparam int NUM_STAGES  = 2 * LEVELS;
    localparam int STAGE_IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    typedef logic [ELEM_WIDTH-1:0]  t_elem;
    typedef t_elem [LANES-1:0]      t_lanes;
    typedef logic [MASK_W-1:0]      t_mask;
    typedef logic [VEC_W-1:0]       t_vec;
    typedef logic [STAGE_IDX_W-1:0] t_stage_idx;

    typedef struct packed {
        logic   valid;
        t_mask  first_sw;
        t_mask  second_sw;
        t_lanes lanes;
    } t_stage_bus;

    // Split the packed vector into lanes; bits past the vector read as zero.
    function automatic t_lanes unpack_vec(t_vec v);
        t_lanes l;
        int     idx;
        l = '0;
        for (int e = 0; e < LANES; e++) begin
            for (int b = 0; b < ELEM_WIDTH; b++) begin
                idx = e * ELEM_WIDTH + b;
                if (idx < VEC_W) begin
                    l[e][b] = v[idx];
                end
            end
        end
        return l;
    endfunction

    // Pack lanes back; bits that land past the vector are dropped.
    function automatic t_vec pack_vec(t_lanes l);
        t_vec v;
        int   idx;
        v = '0;
        for (int e = 0; e < LANES; e++) begin
            for (int b = 0; b < ELEM_WIDTH; b++) begin
                idx = e * ELEM_WIDTH + b;
                if (idx < VEC_W) begin
                    v[idx] = l[e][b];
                end
            end
        end
        return v;
    endfunction

    // One butterfly stage. Stages below LEVELS use the first mask with
    // shrinking blocks; the rest use the second mask with growing blocks.
    function automatic t_lanes stage_swap(t_lanes l, t_mask m1, t_mask m2,
                                          t_stage_idx s);
        t_lanes      r;
        t_mask       m;
        int unsigned sv;
        int unsigned d;
        int unsigned bs;
        int unsigned hbs;
        int unsigned ofs;
        int unsigned pos;
        int unsigned b;
        r  = l;
        sv = int'(s);
        if (sv < LEVELS) begin
            m  = m1;
            d  = sv;
            bs = 1 << (LEVELS - d);
        end else begin
            m  = m2;
            d  = sv - LEVELS;
            bs = 1 << (d + 1);
        end
        hbs = bs >> 1;
        for (int unsigned a = 0; a < LANES; a++) begin
            ofs = a & (bs - 1);
            b   = a + hbs;
            pos = d * (LANES / 2) + ((a - ofs) >> 1) + ofs;
            if (ofs < hbs && b < LANES && pos < MASK_W) begin
                if (m[pos]) begin
                    r[a] = l[b];
                    r[b] = l[a];
                end
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/tmbp_stage.sv
`timescale 1ns / 1ps
// One registered butterfly stage of the permuter pipeline.
// Depends on tmbp_pkg for the bus type and the swap function.

module tmbp_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmbp_pkg::t_stage_idx i_stage,
    input  tmbp_pkg::t_stage_bus i_bus,
    output tmbp_pkg::t_stage_bus o_bus
);
    import tmbp_pkg::*;

    logic   r_valid;
    t_mask  r_first_sw;
    t_mask  r_second_sw;
    t_lanes r_lanes;
    t_lanes n_lanes;

    always_comb begin
        n_lanes = stage_swap(i_bus.lanes, i_bus.first_sw, i_bus.second_sw, i_stage);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    // payload moves every cycle; valid qualifies it
    always_ff @(posedge i_clk) begin
        r_first_sw  <= i_bus.first_sw;
        r_second_sw <= i_bus.second_sw;
        r_lanes     <= n_lanes;
    end

    assign o_bus.valid     = r_valid;
    assign o_bus.first_sw  = r_first_sw;
    assign o_bus.second_sw = r_second_sw;
    assign o_bus.lanes     = r_lanes;

endmodule

// File: hw/rtl/two_mask_butterfly_permuter.sv
`timescale 1ns / 1ps
// Top level of the two-mask butterfly permuter: a chain of registered
// butterfly stages. Depends on tmbp_pkg and tmbp_stage.
//
// Usage:
//   Command channel: drive i_vector_in and both switch masks and raise start.
//   The transfer happens on any rising edge with start high and busy low.
//   busy is held low: the pipeline takes a new vector every cycle.
//   Result channel: o_valid strobes for exactly one cycle with the permuted
//   vector on o_vector_out; the transfer is that cycle's closing edge.
//   There is one register stage per butterfly stage; throughput is one
//   vector per cycle.
//   Results leave in command order. The receiver cannot stall, so nothing
//   is held back: each stage advances every cycle.
//   Reset (synchronous, active low) clears all stage valid bits; vectors in
//   flight are discarded and no strobe follows.

module two_mask_butterfly_permuter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tmbp_pkg::t_vec      i_vector_in,
    input  tmbp_pkg::t_mask     i_first_switches,
    input  tmbp_pkg::t_mask     i_second_switches,
    output logic                o_valid,
    output tmbp_pkg::t_vec      o_vector_out
);
    import tmbp_pkg::*;

    t_stage_bus w_bus [NUM_STAGES+1];

    assign busy = 1'b0;

    always_comb begin
        w_bus[0].valid     = start & ~busy;
        w_bus[0].first_sw  = i_first_switches;
        w_bus[0].second_sw = i_second_switches;
        w_bus[0].lanes     = unpack_vec(i_vector_in);
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        tmbp_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_IDX_W'(g)),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    assign o_valid      = w_bus[NUM_STAGES].valid;
    assign o_vector_out = pack_vec(w_bus[NUM_STAGES].lanes);

endmodule

// File: sim/two_mask_butterfly_permuter_tb.sv
`timescale 1ns / 1ps
// Testbench for two_mask_butterfly_permuter: a directed table, then random vectors
// and masks; results are checked against typed rows or a lane-swap predictor. Depends on tmbp_pkg.

module two_mask_butterfly_permuter_tb;
    import tmbp_pkg::*;

    typedef struct {
        t_vec  vec;
        t_mask fs;
        t_mask ss;
        bit    typed;
        t_vec  out;
    } t_perm_row;

    localparam t_vec PATTERN = 64'h4444_3333_2222_1111;
    localparam t_vec ONES    = '1;
    localparam int   N_RANDOM = 450;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_vec  i_vector_in;
    t_mask i_first_switches;
    t_mask i_second_switches;
    logic  o_valid;
    t_vec  o_vector_out;

    t_vec  expected_vectors[$];
    t_vec  want_vec;
    int    n_fail = 0;
    bit    steady_sender = 1'b0;

    two_mask_butterfly_permuter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_vector_in       (i_vector_in),
        .i_first_switches  (i_first_switches),
        .i_second_switches (i_second_switches),
        .o_valid           (o_valid),
        .o_vector_out      (o_vector_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shrinking-block stages use the first mask, growing-block stages the second.
    function automatic t_vec permute_lanes(t_vec v, t_mask fs, t_mask ss);
        t_elem       ln [LANES];
        t_elem       tmp;
        t_mask       msk;
        t_vec        r;
        int unsigned d;
        int unsigned bsz;
        int unsigned half;
        int unsigned a;
        int unsigned b;
        int unsigned bit_no;
        for (int e = 0; e < LANES; e++) begin
            ln[e] = v[e*ELEM_WIDTH +: ELEM_WIDTH];
        end
        for (int s = 0; s < 2 * LEVELS; s++) begin
            if (s < LEVELS) begin
                msk = fs;
                d   = s;
                bsz = 1 << (LEVELS - d);
            end else begin
                msk = ss;
                d   = s - LEVELS;
                bsz = 1 << (d + 1);
            end
            half = bsz / 2;
            for (int unsigned blk = 0; blk < LANES; blk += bsz) begin
                for (int unsigned i = 0; i < half; i++) begin
                    a      = blk + i;
                    b      = a + half;
                    bit_no = d * (LANES / 2) + blk / 2 + i;
                    if (b < LANES && bit_no < MASK_W && msk[bit_no]) begin
                        tmp   = ln[a];
                        ln[a] = ln[b];
                        ln[b] = tmp;
                    end
                end
            end
        end
        r = '0;
        for (int e = 0; e < LANES; e++) begin
            r[e*ELEM_WIDTH +: ELEM_WIDTH] = ln[e];
        end
        return r;
    endfunction

    task automatic send_vector(input t_vec v, input t_mask fs, input t_mask ss,
                               input bit typed, input t_vec typed_out);
        start             <= 1'b1;
        i_vector_in       <= v;
        i_first_switches  <= fs;
        i_second_switches <= ss;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_vectors.push_back(typed ? typed_out : permute_lanes(v, fs, ss));
        if (!steady_sender && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_vectors.size() != 0) @(posedge i_clk);
    endtask

    // Results cannot be held off: every strobe is a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_vectors.size() == 0) begin
                $error("vector_out: no transfer expected, got %h", o_vector_out);
                n_fail++;
            end else begin
                want_vec = expected_vectors.pop_front();
                if (o_vector_out !== want_vec) begin
                    $error("vector_out: expected %h, got %h", want_vec, o_vector_out);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        t_perm_row rows [$];
        t_vec      v;
        rows = '{
            '{64'h0, 4'h0, 4'h0, 1'b1, 64'h0},
            '{ONES, 4'hF, 4'hF, 1'b1, ONES},
            '{ONES, 4'h0, 4'h0, 1'b1, ONES},
            '{PATTERN, 4'h0, 4'h0, 1'b1, PATTERN},
            '{PATTERN, 4'h1, 4'h0, 1'b0, 64'h0},
            '{PATTERN, 4'h2, 4'h0, 1'b0, 64'h0},
            '{PATTERN, 4'h4, 4'h0, 1'b0, 64'h0},
            '{PATTERN, 4'h8, 4'h0, 1'b0, 64'h0},
            '{PATTERN, 4'h0, 4'h1, 1'b0, 64'h0},
            '{PATTERN, 4'h0, 4'h2, 1'b0, 64'h0},
            '{PATTERN, 4'h0, 4'h4, 1'b0, 64'h0},
            '{PATTERN, 4'h0, 4'h8, 1'b0, 64'h0},
            '{PATTERN, 4'hF, 4'h0, 1'b0, 64'h0},
            '{PATTERN, 4'h0, 4'hF, 1'b0, 64'h0},
            '{PATTERN, 4'hF, 4'hF, 1'b0, 64'h0},
            '{PATTERN, 4'h5, 4'hA, 1'b0, 64'h0},
            '{64'h8000_0000_0000_0001, 4'h3, 4'hC, 1'b0, 64'h0},
            '{64'hFFFF_0000_0000_FFFF, 4'hA, 4'h5, 1'b0, 64'h0},
            '{64'h0123_4567_89AB_CDEF, 4'h9, 4'h6, 1'b0, 64'h0}
        };

        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_vector_in       <= '0;
        i_first_switches  <= '0;
        i_second_switches <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_vector(rows[k].vec, rows[k].fs, rows[k].ss, rows[k].typed, rows[k].out);
        end
        drain_results();

        for (int n = 0; n < N_RANDOM; n++) begin
            // one hold-off until the pipe is empty, then a stretch at full rate
            if (n == 100) begin
                drain_results();
            end
            steady_sender = (n >= 200 && n < 350);
            case ($urandom_range(0, 15))
                0:       v = '0;
                1:       v = ONES;
                default: v = {$urandom, $urandom};
            endcase
            send_vector(v, t_mask'($urandom_range(0, 15)), t_mask'($urandom_range(0, 15)),
                        1'b0, '0);
        end
        drain_results();
        repeat (2 * LEVELS + 4) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tmbp_pkg.sv
hw/rtl/tmbp_stage.sv
hw/rtl/two_mask_butterfly_permuter.sv
sim/two_mask_butterfly_permuter_tb.sv
